@@ hw/rtl/tmacc_pkg.sv @@
`timescale 1ns / 1ps

package tmacc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = WORD_BITS + 1;
  localparam int PORT_BITS = 32;
  localparam int EXT_BITS  = (WORD_BITS > PORT_BITS) ? WORD_BITS : PORT_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PORT_BITS-1:0] port_word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam port_word_t PORT_MAX = {1'b0, {(PORT_BITS-1){1'b1}}};
  localparam port_word_t PORT_MIN = {1'b1, {(PORT_BITS-1){1'b0}}};
  // 1.0 in the word format, clipped when it does not fit
  localparam word_t ONE_VALUE = (FRAC_BITS < WORD_BITS - 1) ?
                                WORD_BITS'(64'sd1 <<< FRAC_BITS) : WORD_MAX;

  typedef enum logic [1:0] {
    REQ_IDENTITY  = 2'd0,
    REQ_CLEAR     = 2'd1,
    REQ_TRANSLATE = 2'd2,
    REQ_SCALE     = 2'd3
  } req_t;

  typedef struct packed {
    req_t       op;
    logic [1:0] row;
    logic [1:0] col;
  } unit_ctl_t;

  // clip a shifted product to the word range
  function automatic word_t sat_prod(input logic signed [PROD_BITS-1:0] v);
    word_t r;
    if (v > PROD_BITS'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < PROD_BITS'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic word_t sat_sum(input logic signed [SUM_BITS-1:0] v);
    word_t r;
    if (v > SUM_BITS'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < SUM_BITS'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // port value into the word format
  function automatic word_t word_from_port(input port_word_t x);
    logic signed [EXT_BITS-1:0] e;
    word_t r;
    e = EXT_BITS'(x);
    if (e > EXT_BITS'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (e < EXT_BITS'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = e[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // word into the port format
  function automatic port_word_t port_from_word(input word_t x);
    logic signed [EXT_BITS-1:0] e;
    port_word_t r;
    e = EXT_BITS'(x);
    if (e > EXT_BITS'(PORT_MAX)) begin
      r = PORT_MAX;
    end else if (e < EXT_BITS'(PORT_MIN)) begin
      r = PORT_MIN;
    end else begin
      r = e[PORT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tmacc_if.sv @@
`timescale 1ns / 1ps

interface tmacc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;

  modport source (output valid, req_type, x_value, y_value, z_value, input ready);
  modport sink (input valid, req_type, x_value, y_value, z_value, output ready);
endinterface

interface tmacc_entry_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic [1:0]         col_index;
  logic signed [31:0] entry_value;
  logic               last_entry;

  modport source (output valid, row_index, col_index, entry_value, last_entry,
                  input ready);
  modport sink (input valid, row_index, col_index, entry_value, last_entry,
                output ready);
endinterface

@@ hw/rtl/transform_matrix_accumulator_core.sv @@
`timescale 1ns / 1ps
// 4x4 homogeneous transform matrix, signed Q16.16, kept in registers.
// req: one request per operation (load identity, clear, translate, scale),
//   accepted when valid and ready are high. x/y/z_value carry the offsets
//   or scale factors and are ignored for identity and clear.
// entry: sixteen results per request, row-major, each with its row and
//   column; last_entry marks the sixteenth.
// One shared multiplier walks the sixteen entries, one per cycle, through a
// product register and an output register. After a request is accepted, each
// entry passes the product register and then the output register, and ready
// rises again once the sixteenth entry sits in the output register.
// When the receiver stalls, the output register and the product register
// hold and the walk pauses; nothing is dropped.
// Reset (rst, synchronous) loads the identity matrix, empties both
// registers and leaves the block ready.

module transform_matrix_accumulator_core import tmacc_pkg::*; (
  input  logic clk,
  input  logic rst,
  tmacc_req_if.sink     req,
  tmacc_entry_if.source entry
);

  word_t      mat_lo [4][3];
  word_t      mat_c3 [4];
  word_t      v_word [3];
  req_t       op;
  logic       busy;
  logic [4:0] issue_count;
  logic       s1_valid;
  logic       out_valid;
  logic [1:0] out_row;
  logic [1:0] out_col;
  port_word_t out_value;
  logic       out_last;

  logic       out_free;
  logic       issue;
  logic       drain;
  logic [1:0] iss_row;
  logic [1:0] iss_col;
  unit_ctl_t  iss_ctl;
  word_t      op_a;
  word_t      op_b;
  word_t      op_base;
  unit_ctl_t  s1_ctl;
  word_t      s1_result;

  assign out_free = !out_valid || entry.ready;
  assign issue    = busy && !issue_count[4] && (!s1_valid || out_free);
  assign drain    = s1_valid && out_free;
  assign iss_row  = issue_count[3:2];
  assign iss_col  = issue_count[1:0];

  always_comb begin
    iss_ctl.op  = op;
    iss_ctl.row = iss_row;
    iss_ctl.col = iss_col;
    if (iss_col == 2'd3) begin
      op_a    = '0;
      op_b    = '0;
      op_base = mat_c3[iss_row];
    end else begin
      op_a    = (op == REQ_TRANSLATE) ? mat_c3[iss_row] : mat_lo[iss_row][iss_col];
      op_b    = v_word[iss_col];
      op_base = mat_lo[iss_row][iss_col];
    end
  end

  tmacc_unit u_unit (
    .clk     (clk),
    .load    (issue),
    .ctl_in  (iss_ctl),
    .a       (op_a),
    .b       (op_b),
    .base_in (op_base),
    .ctl     (s1_ctl),
    .result  (s1_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      issue_count <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      for (int r = 0; r < 4; r++) begin
        mat_c3[r] <= (r == 3) ? ONE_VALUE : '0;
        for (int c = 0; c < 3; c++) begin
          mat_lo[r][c] <= (r == c) ? ONE_VALUE : '0;
        end
      end
    end else begin
      if (req.valid && req.ready) begin
        busy        <= 1'b1;
        issue_count <= '0;
        op          <= req_t'(req.req_type);
        v_word[0]   <= word_from_port(req.x_value);
        v_word[1]   <= word_from_port(req.y_value);
        v_word[2]   <= word_from_port(req.z_value);
      end else if (issue) begin
        issue_count <= issue_count + 5'd1;
      end

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end

      if (drain) begin
        // write back and present the entry
        if (s1_ctl.col == 2'd3) begin
          mat_c3[s1_ctl.row] <= s1_result;
        end else begin
          mat_lo[s1_ctl.row][s1_ctl.col] <= s1_result;
        end
        out_valid <= 1'b1;
        out_row   <= s1_ctl.row;
        out_col   <= s1_ctl.col;
        out_value <= port_from_word(s1_result);
        out_last  <= (s1_ctl.row == 2'd3) && (s1_ctl.col == 2'd3);
        if ((s1_ctl.row == 2'd3) && (s1_ctl.col == 2'd3)) begin
          busy <= 1'b0;
        end
      end else if (entry.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign req.ready         = !busy;
  assign entry.valid       = out_valid;
  assign entry.row_index   = out_row;
  assign entry.col_index   = out_col;
  assign entry.entry_value = out_value;
  assign entry.last_entry  = out_last;

  // idle means the product register is empty
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !s1_valid)
    else $error("product register busy while accepting requests");

  // a stalled product holds its entry
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_ctl))
    else $error("product register lost a stalled entry");

  // last marker only on the bottom right entry
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    entry.valid && entry.last_entry |-> entry.row_index == 2'd3 && entry.col_index == 2'd3)
    else $error("last_entry on wrong position");

  // walk stops after sixteen issues
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_count[4] |-> issue_count[3:0] == 4'd0)
    else $error("issue counter overran");

endmodule

@@ hw/rtl/tmacc_unit.sv @@
`timescale 1ns / 1ps

module tmacc_unit import tmacc_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  unit_ctl_t ctl_in,
  input  word_t     a,
  input  word_t     b,
  input  word_t     base_in,
  output unit_ctl_t ctl,
  output word_t     result
);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] shifted;
  word_t                       base;
  word_t                       scaled;
  logic signed [SUM_BITS-1:0]  sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_BITS'(a) * PROD_BITS'(b);
      base <= base_in;
      ctl  <= ctl_in;
    end
  end

  // arithmetic shift truncates toward minus infinity
  assign shifted = prod >>> FRAC_BITS;
  assign scaled  = sat_prod(shifted);
  assign sum     = SUM_BITS'(base) + SUM_BITS'(scaled);

  always_comb begin
    case (ctl.op)
      REQ_IDENTITY:  result = (ctl.row == ctl.col) ? ONE_VALUE : '0;
      REQ_CLEAR:     result = '0;
      REQ_TRANSLATE: result = (ctl.col == 2'd3) ? base : sat_sum(sum);
      REQ_SCALE:     result = (ctl.col == 2'd3) ? base : scaled;
      default:       result = '0;
    endcase
  end

endmodule

@@ tb/transform_matrix_accumulator_core_tb.sv @@
`timescale 1ns / 1ps

module transform_matrix_accumulator_core_tb import tmacc_pkg::*;;

  localparam int RANDOM_REQUESTS = 396;
  localparam int IDLE_PCT        = 31;
  localparam int DRAIN_CYCLES    = 24;

  localparam port_word_t Q_ONE = 32'sh0001_0000;
  localparam port_word_t Q_MAX = PORT_MAX;
  localparam port_word_t Q_MIN = PORT_MIN;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    port_word_t value;
    logic       last;
  } entry_exp_t;

  // typed rows carry a diagonal matrix that the request must leave behind
  typedef struct packed {
    req_t       op;
    port_word_t x;
    port_word_t y;
    port_word_t z;
    logic       typed;
    port_word_t d0;
    port_word_t d1;
    port_word_t d2;
    port_word_t d3;
  } request_row_t;

  logic clk;
  logic rst;
  logic calm;
  int   fail_count;
  int   entries_checked;
  int   op_count [4];

  word_t        matrix_q [16];
  entry_exp_t   pending_entries [$];
  request_row_t directed_rows [$];

  tmacc_req_if   req_bus ();
  tmacc_entry_if entry_bus ();

  transform_matrix_accumulator_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_bus),
    .entry (entry_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("transform_matrix_accumulator_core_tb: done, errors");
    $finish;
  end

  function automatic word_t clip_word(input wide_t v);
    word_t r;
    if (v > wide_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < wide_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic port_word_t to_port(input word_t w);
    wide_t      v;
    port_word_t r;
    v = wide_t'(w);
    if (v > wide_t'(PORT_MAX)) begin
      r = PORT_MAX;
    end else if (v < wide_t'(PORT_MIN)) begin
      r = PORT_MIN;
    end else begin
      r = v[PORT_BITS-1:0];
    end
    return r;
  endfunction

  // exact product, floored by the shift, then clipped
  function automatic word_t mul_floor(input word_t a, input word_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return clip_word(p >>> FRAC_BITS);
  endfunction

  function automatic void apply_request(input req_t op, input port_word_t x,
                                        input port_word_t y, input port_word_t z);
    word_t factor [3];
    word_t unit;
    word_t w;
    factor[0] = clip_word(wide_t'(x));
    factor[1] = clip_word(wide_t'(y));
    factor[2] = clip_word(wide_t'(z));
    unit = clip_word(wide_t'(1) <<< FRAC_BITS);
    case (op)
      REQ_IDENTITY: begin
        for (int k = 0; k < 16; k++) matrix_q[k] = (k % 5 == 0) ? unit : '0;
      end
      REQ_CLEAR: begin
        for (int k = 0; k < 16; k++) matrix_q[k] = '0;
      end
      REQ_TRANSLATE: begin
        for (int r = 0; r < 4; r++) begin
          w = matrix_q[r*4+3];
          for (int c = 0; c < 3; c++) begin
            matrix_q[r*4+c] = clip_word(wide_t'(matrix_q[r*4+c]) +
                                        wide_t'(mul_floor(w, factor[c])));
          end
        end
      end
      default: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 3; c++) begin
            matrix_q[r*4+c] = mul_floor(matrix_q[r*4+c], factor[c]);
          end
        end
      end
    endcase
  endfunction

  function automatic void queue_entries(input request_row_t row);
    entry_exp_t e;
    port_word_t diag [4];
    diag[0] = row.d0;
    diag[1] = row.d1;
    diag[2] = row.d2;
    diag[3] = row.d3;
    for (int k = 0; k < 16; k++) begin
      e.row = 2'(k / 4);
      e.col = 2'(k % 4);
      if (row.typed) begin
        e.value = (k % 5 == 0) ? diag[k/4] : '0;
      end else begin
        e.value = to_port(matrix_q[k]);
      end
      e.last = (k == 15);
      pending_entries.push_back(e);
    end
  endfunction

  function automatic void add_row(input req_t op, input port_word_t x,
                                  input port_word_t y, input port_word_t z,
                                  input logic typed,
                                  input port_word_t d0, input port_word_t d1,
                                  input port_word_t d2, input port_word_t d3);
    request_row_t row;
    row.op    = op;
    row.x     = x;
    row.y     = y;
    row.z     = z;
    row.typed = typed;
    row.d0    = d0;
    row.d1    = d1;
    row.d2    = d2;
    row.d3    = d3;
    directed_rows.push_back(row);
  endfunction

  function automatic port_word_t rand_operand();
    int unsigned pick;
    port_word_t  v;
    pick = $urandom_range(99);
    if (pick < 30) begin
      v = port_word_t'(int'($urandom_range(32'h3FFFF)) - 32'sh1FFFF);
    end else if (pick < 55) begin
      v = port_word_t'(32'sh0001_0000 + int'($urandom_range(32'h1FFF)) - 4096);
      if ($urandom_range(1) == 1) v = -v;
    end else if (pick < 80) begin
      v = port_word_t'($urandom());
    end else if (pick < 90) begin
      case ($urandom_range(5))
        0: v = Q_MAX;
        1: v = Q_MIN;
        2: v = '0;
        3: v = -1;
        4: v = 1;
        default: v = Q_ONE;
      endcase
    end else begin
      v = port_word_t'(int'($urandom_range(32'hFF_FFFF)) - 32'sh7F_FFFF);
    end
    return v;
  endfunction

  function automatic request_row_t random_row();
    request_row_t row;
    int unsigned  pick;
    row = '0;
    pick = $urandom_range(99);
    if (pick < 10) begin
      row.op = REQ_IDENTITY;
    end else if (pick < 14) begin
      row.op = REQ_CLEAR;
    end else if (pick < 58) begin
      row.op = REQ_TRANSLATE;
    end else begin
      row.op = REQ_SCALE;
    end
    row.x = rand_operand();
    row.y = rand_operand();
    row.z = rand_operand();
    return row;
  endfunction

  task automatic send_request(input request_row_t row);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= row.op;
    req_bus.x_value  <= row.x;
    req_bus.y_value  <= row.y;
    req_bus.z_value  <= row.z;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    apply_request(row.op, row.x, row.y, row.z);
    queue_entries(row);
    op_count[row.op]++;
  endtask

  always @(posedge clk) begin
    entry_exp_t want;
    if (!rst && entry_bus.valid && entry_bus.ready) begin
      if (pending_entries.size() == 0) begin
        $error("entry with no request outstanding: row %0d col %0d value %0d",
               entry_bus.row_index, entry_bus.col_index, entry_bus.entry_value);
        fail_count++;
      end else begin
        want = pending_entries.pop_front();
        entries_checked++;
        if (entry_bus.row_index !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, entry_bus.row_index);
          fail_count++;
        end
        if (entry_bus.col_index !== want.col) begin
          $error("col_index: expected %0d, got %0d", want.col, entry_bus.col_index);
          fail_count++;
        end
        if (entry_bus.entry_value !== want.value) begin
          $error("entry_value [%0d][%0d]: expected %0d, got %0d", want.row, want.col,
                 want.value, entry_bus.entry_value);
          fail_count++;
        end
        if (entry_bus.last_entry !== want.last) begin
          $error("last_entry [%0d][%0d]: expected %0d, got %0d", want.row, want.col,
                 want.last, entry_bus.last_entry);
          fail_count++;
        end
      end
    end
    entry_bus.ready <= rst || calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    rst             = 1'b1;
    calm            = 1'b0;
    fail_count      = 0;
    entries_checked = 0;
    foreach (op_count[k]) op_count[k] = 0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_IDENTITY;
    req_bus.x_value  <= '0;
    req_bus.y_value  <= '0;
    req_bus.z_value  <= '0;
    apply_request(REQ_IDENTITY, '0, '0, '0);

    add_row(REQ_IDENTITY, 0, 0, 0, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_row(REQ_CLEAR, Q_MAX, Q_MIN, -1, 1'b1, 0, 0, 0, 0);
    // column 3 is zero, so nothing moves
    add_row(REQ_TRANSLATE, Q_ONE, Q_MAX, Q_MIN, 1'b1, 0, 0, 0, 0);
    add_row(REQ_SCALE, Q_MAX, Q_MAX, Q_MAX, 1'b1, 0, 0, 0, 0);
    add_row(REQ_IDENTITY, Q_MIN, -1, Q_MAX, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_row(REQ_SCALE, Q_MAX, Q_MAX, Q_MAX, 1'b1, Q_MAX, Q_MAX, Q_MAX, Q_ONE);
    add_row(REQ_SCALE, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 1'b0, 0, 0, 0, 0);
    add_row(REQ_SCALE, -1, -1, -1, 1'b0, 0, 0, 0, 0);
    add_row(REQ_IDENTITY, 0, 0, 0, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_row(REQ_SCALE, Q_MIN, Q_MIN, Q_MIN, 1'b1, Q_MIN, Q_MIN, Q_MIN, Q_ONE);
    add_row(REQ_SCALE, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0, 0);
    add_row(REQ_IDENTITY, 0, 0, 0, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_row(REQ_TRANSLATE, 32'sh0001_8000, -32'sh0002_4000, 1, 1'b0, 0, 0, 0, 0);
    add_row(REQ_TRANSLATE, Q_MAX, Q_MAX, Q_MAX, 1'b0, 0, 0, 0, 0);
    add_row(REQ_TRANSLATE, Q_MAX, Q_MAX, Q_MAX, 1'b0, 0, 0, 0, 0);
    add_row(REQ_TRANSLATE, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0, 0);
    add_row(REQ_TRANSLATE, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0, 0);
    add_row(REQ_TRANSLATE, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0, 0);
    // odd fractions on negative entries floor toward minus infinity
    add_row(REQ_SCALE, 32'sh0000_8001, -32'sh0000_7fff, 1, 1'b0, 0, 0, 0, 0);
    add_row(REQ_SCALE, 0, Q_ONE, -Q_ONE, 1'b0, 0, 0, 0, 0);
    add_row(REQ_IDENTITY, 0, 0, 0, 1'b1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_row(REQ_TRANSLATE, -3, 3, -32'sh0000_8000, 1'b0, 0, 0, 0, 0);
    add_row(REQ_SCALE, 3, -3, 32'sh0000_0002, 1'b0, 0, 0, 0, 0);
    add_row(REQ_CLEAR, Q_ONE, Q_ONE, Q_ONE, 1'b1, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) send_request(directed_rows[k]);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // hold both sides busy through a long stretch
      calm <= (n >= 150 && n < 260);
      send_request(random_row());
    end
    calm          <= 1'b0;
    req_bus.valid <= 1'b0;

    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d identity, %0d clear, %0d translate and %0d scale requests",
             op_count[REQ_IDENTITY], op_count[REQ_CLEAR], op_count[REQ_TRANSLATE],
             op_count[REQ_SCALE]);
    $display("compared %0d matrix entries, %0d mismatches", entries_checked, fail_count);
    if (fail_count == 0) begin
      $display("transform_matrix_accumulator_core_tb: done, clean");
    end else begin
      $display("transform_matrix_accumulator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
